[rtl/core/generational_slot_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define GSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("generational slot allocator: assertion failed");

// Next-cycle implication.
`define GSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("generational slot allocator: assertion failed");

`endif

[rtl/core/gsa_pkg.sv]
package gsa_pkg;

	localparam int FIELD_W   = 16;
	localparam int OUT_IDX_W = 10;

	// Request codes; the code not listed behaves as validate.
	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_FREE     = 2'd1;
	localparam logic [1:0] OP_VALIDATE = 2'd2;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_EXHAUSTED = 3'd1;
	localparam status_t ST_BAD_INDEX = 3'd2;
	localparam status_t ST_SLOT_FREE = 3'd3;
	localparam status_t ST_STALE     = 3'd4;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SLOT_RD,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
	} stk_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_sts_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} tbl_ctl_t;

endpackage

[rtl/core/generational_slot_allocator.sv]
// Generational slot allocator: hands out handles (slot index plus generation)
// from a pool of SLOTS slots. Allocate pops the most recently freed slot (slot
// 0 first after reset), free checks the handle, bumps the slot's generation
// and pushes the slot back, validate only checks. Each request gives exactly
// one result transaction. After reset the slot table is swept clean, which
// keeps in_stall high until the sweep is done. A request then passes through
// accept with free-stack read, slot-table read, and result with write-back,
// and no new request is accepted before the previous one has written back;
// the dependent stack read followed by the slot-table read keeps requests
// from overlapping. A finished result sits in an output register, so a new
// request is accepted while the previous result still waits.
`include "generational_slot_allocator_assert.svh"

module generational_slot_allocator #(
	parameter int SLOTS = 1024,
	parameter int GEN_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] handle_index,
	input  logic [15:0] handle_generation,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  slot_index,
	output logic [15:0] slot_generation
);
	import gsa_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	// Generation compare width: covers both the stored and the handle field.
	localparam int CMP_W = (GEN_BITS > FIELD_W) ? GEN_BITS : FIELD_W;

	state_t state_q, state_d;

	// Request held for the duration of its processing.
	logic [1:0]         op_q;
	logic [FIELD_W-1:0] hidx_q;
	logic [FIELD_W-1:0] hgen_q;
	logic [IDX_W-1:0]   slot_s2;

	stk_ctl_t            stk_ctl;
	stk_sts_t            stk_sts;
	logic [IDX_W-1:0]    stk_top;
	tbl_ctl_t            tbl_ctl;
	logic [IDX_W-1:0]    tbl_rd_addr;
	logic                tbl_ready;
	logic                tbl_occ;
	logic [GEN_BITS-1:0] tbl_gen;

	logic in_acc;
	logic out_free;
	logic exec_fire;

	// Result and write-back decisions for the request in S_EXEC.
	status_t             res_status;
	logic [IDX_W-1:0]    res_slot;
	logic [GEN_BITS-1:0] res_gen;
	logic                do_pop;
	logic                do_push;
	logic                do_wr;
	logic                wr_occ;
	logic [GEN_BITS-1:0] wr_gen;
	logic                in_range;
	logic                gen_match;
	logic [GEN_BITS-1:0] gen_inc;
	logic [FIELD_W-1:0]  slot_ext;
	logic [CMP_W-1:0]    gen_ext;

	// Output register.
	logic               out_valid_q;
	status_t            status_q;
	logic [9:0]         slot_index_q;
	logic [FIELD_W-1:0] slot_gen_q;

	gsa_free_stack #(
		.SLOTS(SLOTS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stk_ctl),
		.push_slot(slot_s2),
		.sts      (stk_sts),
		.top_slot (stk_top)
	);

	gsa_slot_table #(
		.SLOTS   (SLOTS),
		.GEN_BITS(GEN_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tbl_ctl),
		.rd_addr(tbl_rd_addr),
		.wr_addr(slot_s2),
		.wr_occ (wr_occ),
		.wr_gen (wr_gen),
		.ready  (tbl_ready),
		.rd_occ (tbl_occ),
		.rd_gen (tbl_gen)
	);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (tbl_ready) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_SLOT_RD;
			end
			S_SLOT_RD: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// State outputs: stall, memory reads and commit strobes.
	always_comb begin
		in_stall     = (state_q != S_IDLE);
		exec_fire    = (state_q == S_EXEC) && out_free;
		stk_ctl.rd   = in_acc;
		stk_ctl.pop  = exec_fire && do_pop;
		stk_ctl.push = exec_fire && do_push;
		tbl_ctl.rd   = (state_q == S_SLOT_RD);
		tbl_ctl.wr   = exec_fire && do_wr;
	end

	// Allocate reads the table at the popped slot, the others at the handle.
	assign tbl_rd_addr = (op_q == OP_ALLOC) ? stk_top : hidx_q[IDX_W-1:0];

	assign in_range  = ({1'b0, hidx_q} < (FIELD_W + 1)'(SLOTS));
	assign gen_match = (CMP_W'(tbl_gen) == CMP_W'(hgen_q));
	assign gen_inc   = tbl_gen + GEN_BITS'(1);

	always_comb begin
		res_status = ST_OK;
		res_slot   = '0;
		res_gen    = '0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		do_wr      = 1'b0;
		wr_occ     = 1'b0;
		wr_gen     = tbl_gen;
		case (op_q)
			OP_ALLOC: begin
				if (stk_sts.empty) begin
					res_status = ST_EXHAUSTED;
				end else begin
					do_pop   = 1'b1;
					do_wr    = 1'b1;
					wr_occ   = 1'b1;
					res_slot = slot_s2;
					res_gen  = tbl_gen;
				end
			end
			default: begin
				if (!in_range) begin
					res_status = ST_BAD_INDEX;
				end else if (!tbl_occ) begin
					res_status = ST_SLOT_FREE;
				end else if (!gen_match) begin
					res_status = ST_STALE;
				end else begin
					res_slot = slot_s2;
					if (op_q == OP_FREE) begin
						do_wr   = 1'b1;
						wr_occ  = 1'b0;
						wr_gen  = gen_inc;
						do_push = !stk_sts.full;
						res_gen = gen_inc;
					end else begin
						res_gen = tbl_gen;
					end
				end
			end
		endcase
	end

	assign slot_ext = FIELD_W'(res_slot);
	assign gen_ext  = CMP_W'(res_gen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request, then the slot it resolves to, then the result.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= operation;
			hidx_q <= handle_index;
			hgen_q <= handle_generation;
		end
		if (state_q == S_SLOT_RD) begin
			slot_s2 <= tbl_rd_addr;
		end
		if (exec_fire) begin
			status_q     <= res_status;
			slot_index_q <= slot_ext[OUT_IDX_W-1:0];
			slot_gen_q   <= gen_ext[FIELD_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign slot_index      = slot_index_q;
	assign slot_generation = slot_gen_q;

	// A popped slot must not already be handed out.
	`GSA_ASSERT_IMP(a_alloc_slot_unoccupied, exec_fire && op_q == OP_ALLOC && !stk_sts.empty, !tbl_occ)
	// A successful free always finds room on the stack.
	`GSA_ASSERT_IMP(a_free_has_room, exec_fire && op_q == OP_FREE && res_status == ST_OK, !stk_sts.full)
	// Hold the finished request while the output register is still occupied.
	`GSA_ASSERT_NEXT(a_exec_holds_on_stall, state_q == S_EXEC && out_valid_q && out_stall, state_q == S_EXEC)

endmodule

[rtl/core/gsa_free_stack.sv]
`include "generational_slot_allocator_assert.svh"

module gsa_free_stack #(
	parameter int SLOTS = 1024,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gsa_pkg::stk_ctl_t ctl,
	input  logic [IDX_W-1:0] push_slot,
	output gsa_pkg::stk_sts_t sts,
	output logic [IDX_W-1:0] top_slot
);
	import gsa_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);

	logic [IDX_W-1:0] mem [SLOTS];
	logic [CNT_W-1:0] count_q;
	// Lowest fill level reached since reset; entries below it were never
	// written, so their slot number is computed rather than read.
	logic [CNT_W-1:0] floor_q;
	logic [IDX_W-1:0] rd_data_q;
	logic [IDX_W-1:0] pristine_val_q;
	logic             pristine_q;
	logic [IDX_W-1:0] top_addr;
	logic [IDX_W-1:0] push_addr;

	assign top_addr  = IDX_W'(count_q - CNT_W'(1));
	assign push_addr = IDX_W'(count_q);
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CNT_W'(SLOTS));
	assign top_slot  = pristine_q ? pristine_val_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q      <= mem[top_addr];
			pristine_q     <= (count_q == floor_q);
			pristine_val_q <= IDX_W'(CNT_W'(SLOTS) - count_q);
		end
		if (ctl.push) begin
			mem[push_addr] <= push_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(SLOTS);
			floor_q <= CNT_W'(SLOTS);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == floor_q) begin
				floor_q <= count_q - CNT_W'(1);
			end
		end else if (ctl.push) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	`GSA_ASSERT_IMP(a_pop_not_empty, ctl.pop, count_q != '0)
	`GSA_ASSERT_IMP(a_floor_not_above_count, 1'b1, floor_q <= count_q)

endmodule

[rtl/core/gsa_slot_table.sv]
module gsa_slot_table #(
	parameter int SLOTS = 1024,
	parameter int GEN_BITS = 16,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gsa_pkg::tbl_ctl_t   ctl,
	input  logic [IDX_W-1:0]    rd_addr,
	input  logic [IDX_W-1:0]    wr_addr,
	input  logic                wr_occ,
	input  logic [GEN_BITS-1:0] wr_gen,
	output logic                ready,
	output logic                rd_occ,
	output logic [GEN_BITS-1:0] rd_gen
);
	import gsa_pkg::*;

	localparam int ENT_W = GEN_BITS + 1;

	logic [ENT_W-1:0] mem [SLOTS];
	logic [ENT_W-1:0] rd_data_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic             clearing_q;

	assign ready  = !clearing_q;
	assign rd_occ = rd_data_q[ENT_W-1];
	assign rd_gen = rd_data_q[GEN_BITS-1:0];

	// Sweep every entry to zero after reset, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == IDX_W'(SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr) begin
			mem[wr_addr] <= {wr_occ, wr_gen};
		end
		if (ctl.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule
